// File: hdl/avs_vc_pkg.sv
package avs_vc_pkg;

  localparam int UV_W       = 21;
  localparam int MARGIN_W   = 18;
  localparam int FUNC_W     = 3;
  localparam int ACT_W      = 3;
  localparam int TRIG_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;

  localparam int STABLE_SAMPLES_DEF = 10;
  localparam int MAX_TRIGGERS_DEF   = 5;

  localparam logic [UV_W-1:0] NOMINAL_RESET      = 21'd1200000;
  localparam logic [UV_W-1:0] HIGH_NOMINAL_LIMIT = 21'd1310000;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ENABLE  = 3'd0,
    FUNC_SAMPLE  = 3'd1,
    FUNC_TICK    = 3'd2,
    FUNC_DISABLE = 3'd3,
    FUNC_CLEAR   = 3'd4
  } func_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE    = 3'd0,
    ACT_ARMED   = 3'd1,
    ACT_DONE    = 3'd2,
    ACT_BUSY    = 3'd3,
    ACT_RESET_V = 3'd4,
    ACT_SKIPPED = 3'd5
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NOMINAL = 2'd0,
    CFG_MARGIN  = 2'd1,
    CFG_ALLOW_HV = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic    latch_in;
    logic    commit;
    action_e action;
    logic    set_active;
    logic    clr_active;
    logic    arm;
    logic    clr_armed;
    logic    clr_trig;
    logic    inc_trig;
    logic    write_sample;
    logic    set_cal_nominal;
    logic    clr_cal;
    logic    load_max;
    logic    scan_step;
    logic    finish;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              vreset;
    logic              active;
    logic              armed;
    logic              cal_zero;
    logic              high_nom;
    logic              trig_first;
    logic              trig_last;
    logic              cnt_zero;
    logic              volt_below_nom;
    logic              scan_end;
  } status_t;

endpackage

// File: hdl/avs_vc_if.sv
interface avs_vc_in_if;
  logic                           valid;
  logic                           ready;
  logic [avs_vc_pkg::FUNC_W-1:0]  func;
  logic [avs_vc_pkg::UV_W-1:0]    volt_uv;
  logic                           volt_reset;

  modport source (output valid, output func, output volt_uv, output volt_reset, input ready);
  modport sink   (input valid, input func, input volt_uv, input volt_reset, output ready);
endinterface

interface avs_vc_out_if;
  logic                          valid;
  logic                          ready;
  logic [avs_vc_pkg::ACT_W-1:0]  action;
  logic [avs_vc_pkg::UV_W-1:0]   calibrated_uv;
  logic                          rescale_needed;
  logic                          margin_refused;

  modport source (output valid, output action, output calibrated_uv, output rescale_needed,
                  output margin_refused, input ready);
  modport sink   (input valid, input action, input calibrated_uv, input rescale_needed,
                  input margin_refused, output ready);
endinterface

// File: hdl/avs_vc_datapath.sv
module avs_vc_datapath #(
  parameter int STABLE_SAMPLES = avs_vc_pkg::STABLE_SAMPLES_DEF,
  parameter int MAX_TRIGGERS   = avs_vc_pkg::MAX_TRIGGERS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [avs_vc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [avs_vc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [avs_vc_pkg::FUNC_W-1:0]     in_func_i,
  input  logic [avs_vc_pkg::UV_W-1:0]       in_volt_i,
  input  logic                              in_vreset_i,
  input  avs_vc_pkg::cmd_t                  cmd_i,
  output avs_vc_pkg::status_t               status_o,
  output logic [avs_vc_pkg::ACT_W-1:0]      out_action_o,
  output logic [avs_vc_pkg::UV_W-1:0]       out_cal_o,
  output logic                              out_rescale_o,
  output logic                              out_refused_o
);

  localparam int IDX_W = (STABLE_SAMPLES > 1) ? $clog2(STABLE_SAMPLES) : 1;
  localparam int CNT_W = $clog2(STABLE_SAMPLES + 1);
  localparam int UV_W  = avs_vc_pkg::UV_W;

  // configuration
  logic [UV_W-1:0]                  nominal_q;
  logic [avs_vc_pkg::MARGIN_W-1:0]  margin_q;
  logic                             allow_hv_q;

  // latched transaction
  logic [avs_vc_pkg::FUNC_W-1:0]    func_q;
  logic [UV_W-1:0]                  volt_q;
  logic                             vreset_q;

  // calibration state
  logic                             active_q;
  logic                             armed_q;
  logic [avs_vc_pkg::TRIG_W-1:0]    trig_q, trig_next;
  logic [CNT_W-1:0]                 sample_cnt_q;
  logic [IDX_W-1:0]                 wp_q;
  logic [UV_W-1:0]                  cal_q, cal_d;

  // scan
  logic [UV_W-1:0]                  sample_mem [STABLE_SAMPLES];
  logic [CNT_W-1:0]                 scan_idx_q;
  logic [UV_W-1:0]                  rd_data_q;
  logic                             rd_vld_q;
  logic [UV_W-1:0]                  max_q;

  // finish arithmetic
  logic [UV_W-1:0]                  safe_clamped;
  logic [UV_W:0]                    safe_sum;
  logic [UV_W-1:0]                  safe_fin;
  logic                             refused_fin;

  // output register
  logic [avs_vc_pkg::ACT_W-1:0]     out_action_q;
  logic [UV_W-1:0]                  out_cal_q;
  logic                             out_rescale_q;
  logic                             out_refused_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nominal_q  <= avs_vc_pkg::NOMINAL_RESET;
      margin_q   <= '0;
      allow_hv_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        avs_vc_pkg::CFG_NOMINAL:  nominal_q  <= cfg_wdata_i[UV_W-1:0];
        avs_vc_pkg::CFG_MARGIN:   margin_q   <= cfg_wdata_i[avs_vc_pkg::MARGIN_W-1:0];
        avs_vc_pkg::CFG_ALLOW_HV: allow_hv_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      func_q   <= in_func_i;
      volt_q   <= in_volt_i;
      vreset_q <= in_vreset_i;
    end
  end

  assign trig_next = (trig_q == '1) ? trig_q : trig_q + 1'b1;

  always_comb begin
    safe_clamped = (max_q > nominal_q) ? nominal_q : max_q;
    safe_sum     = {1'b0, safe_clamped} + {{(UV_W + 1 - avs_vc_pkg::MARGIN_W){1'b0}}, margin_q};
    safe_fin     = safe_clamped;
    refused_fin  = 1'b0;
    if (margin_q != '0) begin
      if (safe_sum < {1'b0, nominal_q}) begin
        safe_fin = safe_sum[UV_W-1:0];
      end else begin
        refused_fin = 1'b1;
      end
    end
  end

  always_comb begin
    cal_d = cal_q;
    if (cmd_i.set_cal_nominal) begin
      cal_d = nominal_q;
    end else if (cmd_i.clr_cal) begin
      cal_d = '0;
    end else if (cmd_i.finish) begin
      cal_d = safe_fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      armed_q      <= 1'b0;
      trig_q       <= '0;
      sample_cnt_q <= '0;
      wp_q         <= '0;
      cal_q        <= '0;
      scan_idx_q   <= '0;
      rd_vld_q     <= 1'b0;
    end else begin
      cal_q    <= cal_d;
      rd_vld_q <= cmd_i.scan_step;

      if (cmd_i.set_active) begin
        active_q <= 1'b1;
      end else if (cmd_i.clr_active || cmd_i.finish) begin
        active_q <= 1'b0;
      end

      if (cmd_i.arm) begin
        armed_q      <= 1'b1;
        sample_cnt_q <= '0;
        wp_q         <= '0;
      end else begin
        if (cmd_i.clr_armed || cmd_i.finish) begin
          armed_q <= 1'b0;
        end
        if (cmd_i.write_sample) begin
          wp_q <= (wp_q == IDX_W'(STABLE_SAMPLES - 1)) ? '0 : wp_q + 1'b1;
          if (sample_cnt_q < CNT_W'(STABLE_SAMPLES)) begin
            sample_cnt_q <= sample_cnt_q + 1'b1;
          end
        end
      end

      if (cmd_i.clr_trig) begin
        trig_q <= '0;
      end else if (cmd_i.inc_trig) begin
        trig_q <= trig_next;
      end

      if (cmd_i.load_max) begin
        scan_idx_q <= '0;
      end else if (cmd_i.scan_step) begin
        scan_idx_q <= scan_idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_sample) begin
      sample_mem[wp_q] <= volt_q;
    end
    if (cmd_i.scan_step) begin
      rd_data_q <= sample_mem[scan_idx_q[IDX_W-1:0]];
    end
  end

  // running maximum, seeded with the present voltage
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_max) begin
      max_q <= volt_q;
    end else if (rd_vld_q && (rd_data_q > max_q)) begin
      max_q <= rd_data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_action_q  <= cmd_i.action;
      out_cal_q     <= cal_d;
      out_rescale_q <= cmd_i.finish && (cal_d != volt_q);
      out_refused_q <= cmd_i.finish && refused_fin;
    end
  end

  assign status_o.func           = func_q;
  assign status_o.vreset         = vreset_q;
  assign status_o.active         = active_q;
  assign status_o.armed          = armed_q;
  assign status_o.cal_zero       = (cal_q == '0);
  assign status_o.high_nom       = !allow_hv_q && (nominal_q > avs_vc_pkg::HIGH_NOMINAL_LIMIT);
  assign status_o.trig_first     = (trig_q == '0);
  assign status_o.trig_last      = (trig_next >= avs_vc_pkg::TRIG_W'(MAX_TRIGGERS));
  assign status_o.cnt_zero       = (sample_cnt_q == '0);
  assign status_o.volt_below_nom = (volt_q < nominal_q);
  assign status_o.scan_end       = (scan_idx_q == sample_cnt_q);

  assign out_action_o  = out_action_q;
  assign out_cal_o     = out_cal_q;
  assign out_rescale_o = out_rescale_q;
  assign out_refused_o = out_refused_q;

endmodule

// File: hdl/avs_vc_ctrl.sv
module avs_vc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  avs_vc_pkg::status_t status_i,
  output avs_vc_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EXEC   = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d      = S_IDLE;
        cmd_o.commit = 1'b1;
        cmd_o.action = avs_vc_pkg::ACT_NONE;
        case (status_i.func)
          avs_vc_pkg::FUNC_ENABLE: begin
            if (!status_i.cal_zero) begin
              cmd_o.action = avs_vc_pkg::ACT_NONE;
            end else if (status_i.high_nom) begin
              cmd_o.set_cal_nominal = 1'b1;
              cmd_o.action          = avs_vc_pkg::ACT_SKIPPED;
            end else if (!status_i.active) begin
              cmd_o.set_active = 1'b1;
              cmd_o.clr_trig   = 1'b1;
              cmd_o.action     = avs_vc_pkg::ACT_ARMED;
            end
          end
          avs_vc_pkg::FUNC_SAMPLE: begin
            cmd_o.write_sample = status_i.armed;
          end
          avs_vc_pkg::FUNC_TICK: begin
            if (status_i.active) begin
              cmd_o.inc_trig = 1'b1;
              if (status_i.trig_first) begin
                cmd_o.arm    = 1'b1;
                cmd_o.action = avs_vc_pkg::ACT_ARMED;
              end else begin
                cmd_o.clr_armed = 1'b1;
                if (status_i.trig_last) begin
                  // result follows once the stored samples are scanned
                  cmd_o.load_max = 1'b1;
                  cmd_o.commit   = 1'b0;
                  state_d        = S_SCAN;
                end else if (status_i.cnt_zero && status_i.volt_below_nom) begin
                  cmd_o.load_max = 1'b1;
                  cmd_o.commit   = 1'b0;
                  state_d        = S_FINISH;
                end else begin
                  cmd_o.arm    = 1'b1;
                  cmd_o.action = avs_vc_pkg::ACT_ARMED;
                end
              end
            end
          end
          avs_vc_pkg::FUNC_DISABLE: begin
            if (status_i.active && status_i.vreset) begin
              cmd_o.action = avs_vc_pkg::ACT_BUSY;
            end else begin
              cmd_o.clr_active = 1'b1;
              cmd_o.clr_armed  = 1'b1;
              if (status_i.cal_zero && status_i.vreset) begin
                cmd_o.action = avs_vc_pkg::ACT_RESET_V;
              end
            end
          end
          avs_vc_pkg::FUNC_CLEAR: begin
            cmd_o.clr_cal = 1'b1;
          end
          default: ;
        endcase
        // hold until the output register can take the result
        if (cmd_o.commit && !slot_free) begin
          cmd_o   = '0;
          state_d = S_EXEC;
        end
      end
      S_SCAN: begin
        if (!status_i.scan_end) begin
          cmd_o.scan_step = 1'b1;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd_o.finish = 1'b1;
          cmd_o.commit = 1'b1;
          cmd_o.action = avs_vc_pkg::ACT_DONE;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_commit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_valid_q || out_ready_i))
    else $error("result written over a pending transaction");

  a_valid_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.commit))
    else $error("output valid raised without a result");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_EXEC))
    else $error("accepted transaction not executed");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.scan_step |-> (!status_i.scan_end && state_q == S_SCAN))
    else $error("scan read past the stored samples");
`endif

endmodule

// File: hdl/avs_voltage_calibration_ctrl_unit.sv
// Calibration controller for adaptive voltage scaling. One transaction in gives exactly one
// transaction out. With the output register free, enable, sample, disable, clear and ticks
// that arm sampling or are ignored return to idle through the execute state. A tick that
// finishes on the present voltage because no samples were stored passes the execute and
// finish states; the last tick also passes the scan state between them, which finds the
// maximum of the n stored samples (n at most STABLE_SAMPLES) by reading the sample memory's
// single read port one entry per cycle. A finished result waits in an output register, so a
// new transaction is accepted while the previous result is pending; that new transaction
// holds the input until the pending result is taken. Configuration is to be written through
// the plain write port only while the block is idle; the block does not enforce it.
module avs_voltage_calibration_ctrl_unit #(
  parameter int STABLE_SAMPLES = avs_vc_pkg::STABLE_SAMPLES_DEF,
  parameter int MAX_TRIGGERS   = avs_vc_pkg::MAX_TRIGGERS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [avs_vc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [avs_vc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  avs_vc_in_if.sink                         in_ch,
  avs_vc_out_if.source                      out_ch
);

  avs_vc_pkg::cmd_t    cmd;
  avs_vc_pkg::status_t status;

  avs_vc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  avs_vc_datapath #(
    .STABLE_SAMPLES (STABLE_SAMPLES),
    .MAX_TRIGGERS   (MAX_TRIGGERS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_func_i     (in_ch.func),
    .in_volt_i     (in_ch.volt_uv),
    .in_vreset_i   (in_ch.volt_reset),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_action_o  (out_ch.action),
    .out_cal_o     (out_ch.calibrated_uv),
    .out_rescale_o (out_ch.rescale_needed),
    .out_refused_o (out_ch.margin_refused)
  );

endmodule

// File: tb/tb_avs_voltage_calibration_ctrl_unit.sv
`timescale 1ns / 1ps

module tb_avs_voltage_calibration_ctrl_unit;

  localparam int UV_W       = avs_vc_pkg::UV_W;
  localparam int MARGIN_W   = avs_vc_pkg::MARGIN_W;
  localparam int FUNC_W     = avs_vc_pkg::FUNC_W;
  localparam int TRIG_W     = avs_vc_pkg::TRIG_W;
  localparam int CFG_IDX_W  = avs_vc_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = avs_vc_pkg::CFG_DATA_W;
  localparam int RING_DEPTH = avs_vc_pkg::STABLE_SAMPLES_DEF;
  localparam int TICK_LAST  = avs_vc_pkg::MAX_TRIGGERS_DEF;

  localparam int CLK_HALF     = 6;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_CYCLE = 16;
  localparam int TICK_SAT     = (1 << TRIG_W) - 1;
  localparam logic [UV_W-1:0]     UV_MAX     = {UV_W{1'b1}};
  localparam logic [MARGIN_W-1:0] MARGIN_MAX = {MARGIN_W{1'b1}};

  typedef struct packed {
    avs_vc_pkg::action_e action;
    logic [UV_W-1:0]     cal_uv;
    logic                rescale;
    logic                refused;
  } cal_result_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  avs_vc_in_if  in_bus ();
  avs_vc_out_if out_bus ();

  avs_voltage_calibration_ctrl_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_bus),
    .out_ch      (out_bus)
  );

  // Predictor copy of the controller
  logic [UV_W-1:0]     reg_nominal;
  logic [MARGIN_W-1:0] reg_margin;
  logic                reg_allow_hv;
  logic                st_active;
  logic                st_armed;
  int                  st_ticks;
  int                  st_count;
  int                  st_wptr;
  logic [UV_W-1:0]     st_ring [RING_DEPTH];
  logic [UV_W-1:0]     st_cal;
  logic                step_ignored;

  cal_result_t cal_expect_q[$];

  logic idle_en;
  logic hold_req;
  int   hold_len;
  int   err_cnt;
  int   checked_cnt;
  int   done_cnt;
  int   useful_cnt;
  int   sent_cnt;
  int   cfg_writes;
  int   cycle_cnt;

  always begin
    clk_i = 1'b1;
    #CLK_HALF;
    clk_i = 1'b0;
    #CLK_HALF;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic void restart_sampling();
    st_count = 0;
    st_wptr  = 0;
    st_armed = 1'b1;
  endfunction

  function automatic cal_result_t predict_cal(input logic [FUNC_W-1:0] fn,
                                              input logic [UV_W-1:0] volt,
                                              input logic vrst);
    cal_result_t r;
    logic [31:0] safe;
    logic        done;
    r.action     = avs_vc_pkg::ACT_NONE;
    r.rescale    = 1'b0;
    r.refused    = 1'b0;
    step_ignored = 1'b0;
    done         = 1'b0;
    safe         = {11'b0, volt};
    case (fn)
      avs_vc_pkg::FUNC_ENABLE: begin
        if (st_cal != '0) begin
          step_ignored = 1'b1;
        end else if (!reg_allow_hv && reg_nominal > avs_vc_pkg::HIGH_NOMINAL_LIMIT) begin
          st_cal   = reg_nominal;
          r.action = avs_vc_pkg::ACT_SKIPPED;
        end else if (!st_active) begin
          st_active = 1'b1;
          st_ticks  = 0;
          r.action  = avs_vc_pkg::ACT_ARMED;
        end else begin
          step_ignored = 1'b1;
        end
      end
      avs_vc_pkg::FUNC_SAMPLE: begin
        if (st_armed) begin
          st_ring[st_wptr] = volt;
          st_wptr = (st_wptr + 1) % RING_DEPTH;
          if (st_count < RING_DEPTH) st_count++;
        end else begin
          step_ignored = 1'b1;
        end
      end
      avs_vc_pkg::FUNC_TICK: begin
        if (!st_active) begin
          step_ignored = 1'b1;
        end else begin
          if (st_ticks < TICK_SAT) st_ticks++;
          if (st_ticks == 1) begin
            restart_sampling();
            r.action = avs_vc_pkg::ACT_ARMED;
          end else begin
            st_armed = 1'b0;
            if (st_ticks >= TICK_LAST) begin
              for (int i = 0; i < st_count; i++)
                if (st_ring[i] > safe) safe = st_ring[i];
              if (safe > reg_nominal) safe = reg_nominal;
              done = 1'b1;
            end else if (st_count == 0 && volt < reg_nominal) begin
              done = 1'b1;
            end else begin
              restart_sampling();
              r.action = avs_vc_pkg::ACT_ARMED;
            end
          end
          if (done) begin
            if (reg_margin != '0) begin
              if (safe + reg_margin < reg_nominal) safe = safe + reg_margin;
              else r.refused = 1'b1;
            end
            st_cal    = safe[UV_W-1:0];
            r.rescale = (st_cal != volt);
            st_active = 1'b0;
            st_armed  = 1'b0;
            r.action  = avs_vc_pkg::ACT_DONE;
          end
        end
      end
      avs_vc_pkg::FUNC_DISABLE: begin
        if (st_active && vrst) begin
          r.action = avs_vc_pkg::ACT_BUSY;
        end else begin
          st_active = 1'b0;
          st_armed  = 1'b0;
          if (st_cal == '0 && vrst) r.action = avs_vc_pkg::ACT_RESET_V;
        end
      end
      avs_vc_pkg::FUNC_CLEAR: st_cal = '0;
      default: step_ignored = 1'b1;
    endcase
    r.cal_uv = st_cal;
    return r;
  endfunction

  task automatic send_cmd(input logic [FUNC_W-1:0] fn, input logic [UV_W-1:0] volt,
                          input logic vrst);
    int gap;
    gap = idle_en ? $urandom_range(0, 4) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_bus.valid      <= 1'b1;
    in_bus.func       <= fn;
    in_bus.volt_uv    <= volt;
    in_bus.volt_reset <= vrst;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    cal_expect_q.push_back(predict_cal(fn, volt, vrst));
    sent_cnt++;
    if (!step_ignored) useful_cnt++;
  endtask

  // Hold the sender until every result is back, then let the block settle
  task automatic drain();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (cal_expect_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLE) @(negedge clk_i);
  endtask

  task automatic write_reg(input avs_vc_pkg::cfg_idx_e idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      avs_vc_pkg::CFG_NOMINAL:  reg_nominal  = val[UV_W-1:0];
      avs_vc_pkg::CFG_MARGIN:   reg_margin   = val[MARGIN_W-1:0];
      avs_vc_pkg::CFG_ALLOW_HV: reg_allow_hv = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_writes++;
  endtask

  task automatic configure(input logic [UV_W-1:0] nom, input logic [MARGIN_W-1:0] mar,
                           input logic hv);
    drain();
    write_reg(avs_vc_pkg::CFG_NOMINAL, nom);
    write_reg(avs_vc_pkg::CFG_MARGIN, CFG_DATA_W'(mar));
    write_reg(avs_vc_pkg::CFG_ALLOW_HV, CFG_DATA_W'(hv));
  endtask

  function automatic logic [UV_W-1:0] pick_volt();
    int sel;
    int v;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return '0;
      1: return UV_MAX;
      2, 3: return UV_W'($urandom());
      default: begin
        v = int'(reg_nominal) + $urandom_range(0, 120000) - 80000;
        if (v < 0) v = 0;
        if (v > int'(UV_MAX)) v = int'(UV_MAX);
        return UV_W'(v);
      end
    endcase
  endfunction

  task automatic send_noise();
    send_cmd(FUNC_W'($urandom_range(0, (1 << FUNC_W) - 1)), pick_volt(), 1'($urandom()));
  endtask

  // One enable followed by ticks with bursts of samples in between
  task automatic run_calibration();
    int n_ticks;
    int n_samp;
    if ($urandom_range(0, 4) != 0)
      send_cmd(avs_vc_pkg::FUNC_CLEAR, pick_volt(), 1'($urandom()));
    send_cmd(avs_vc_pkg::FUNC_ENABLE, pick_volt(), 1'($urandom()));
    n_ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : TICK_LAST;
    for (int t = 0; t < n_ticks; t++) begin
      send_cmd(avs_vc_pkg::FUNC_TICK, pick_volt(), 1'($urandom()));
      case ($urandom_range(0, 3))
        0: n_samp = 0;
        1: n_samp = $urandom_range(1, 3);
        2: n_samp = $urandom_range(4, 9);
        default: n_samp = $urandom_range(10, 14);
      endcase
      for (int s = 0; s < n_samp; s++) begin
        send_cmd(avs_vc_pkg::FUNC_SAMPLE, pick_volt(), 1'($urandom()));
        if ($urandom_range(0, 39) == 0) send_noise();
      end
    end
  endtask

  task automatic run_random(input int n_items, input logic [UV_W-1:0] nom,
                            input logic [MARGIN_W-1:0] mar, input logic hv, input logic idle);
    int start;
    configure(nom, mar, hv);
    idle_en = idle;
    start   = sent_cnt;
    while (sent_cnt - start < n_items) begin
      if ($urandom_range(0, 9) < 8) run_calibration();
      else send_noise();
    end
  endtask

  task automatic test_idle_commands();
    send_cmd(avs_vc_pkg::FUNC_TICK, UV_MAX, 1'b1);
    send_cmd(avs_vc_pkg::FUNC_SAMPLE, UV_MAX, 1'b0);
    send_cmd(avs_vc_pkg::FUNC_DISABLE, '0, 1'b1);
    send_cmd(avs_vc_pkg::FUNC_DISABLE, UV_MAX, 1'b0);
    for (int f = avs_vc_pkg::FUNC_CLEAR + 1; f < (1 << FUNC_W); f++)
      send_cmd(FUNC_W'(f), UV_MAX, 1'b1);
  endtask

  task automatic test_full_calibration();
    send_cmd(avs_vc_pkg::FUNC_ENABLE, '0, 1'b0);
    send_cmd(avs_vc_pkg::FUNC_ENABLE, '0, 1'b0);
    send_cmd(avs_vc_pkg::FUNC_DISABLE, '0, 1'b1);
    send_cmd(avs_vc_pkg::FUNC_TICK, avs_vc_pkg::NOMINAL_RESET, 1'b0);
    send_cmd(avs_vc_pkg::FUNC_SAMPLE, '0, 1'b0);
    send_cmd(avs_vc_pkg::FUNC_SAMPLE, UV_MAX, 1'b0);
    send_cmd(avs_vc_pkg::FUNC_TICK, 21'd1000000, 1'b0);
    send_cmd(avs_vc_pkg::FUNC_TICK, avs_vc_pkg::NOMINAL_RESET, 1'b0);
    send_cmd(avs_vc_pkg::FUNC_SAMPLE, 21'd1150000, 1'b0);
    send_cmd(avs_vc_pkg::FUNC_TICK, 21'd1100000, 1'b0);
    send_cmd(avs_vc_pkg::FUNC_SAMPLE, 21'd1190000, 1'b0);
    send_cmd(avs_vc_pkg::FUNC_SAMPLE, UV_MAX, 1'b0);
    send_cmd(avs_vc_pkg::FUNC_TICK, 21'd1000000, 1'b0);
    send_cmd(avs_vc_pkg::FUNC_ENABLE, '0, 1'b0);
  endtask

  task automatic test_silent_and_stop();
    send_cmd(avs_vc_pkg::FUNC_CLEAR, '0, 1'b0);
    send_cmd(avs_vc_pkg::FUNC_ENABLE, '0, 1'b0);
    send_cmd(avs_vc_pkg::FUNC_TICK, 21'd900000, 1'b0);
    send_cmd(avs_vc_pkg::FUNC_TICK, 21'd900000, 1'b0);
    send_cmd(avs_vc_pkg::FUNC_CLEAR, '0, 1'b0);
    send_cmd(avs_vc_pkg::FUNC_ENABLE, '0, 1'b0);
    send_cmd(avs_vc_pkg::FUNC_DISABLE, '0, 1'b0);
    send_cmd(avs_vc_pkg::FUNC_TICK, 21'd900000, 1'b0);
  endtask

  task automatic test_high_nominal();
    configure(21'd1400000, '0, 1'b0);
    send_cmd(avs_vc_pkg::FUNC_CLEAR, '0, 1'b0);
    send_cmd(avs_vc_pkg::FUNC_ENABLE, '0, 1'b0);
    send_cmd(avs_vc_pkg::FUNC_ENABLE, '0, 1'b0);
  endtask

  // Stall the result side long enough that the block backs up into its input
  task automatic test_backpressure();
    int start;
    configure(avs_vc_pkg::NOMINAL_RESET, 18'd30000, 1'b0);
    idle_en  = 1'b0;
    hold_len = 120;
    hold_req = 1'b1;
    start    = sent_cnt;
    while (sent_cnt - start < 100) run_calibration();
    drain();
  endtask

  initial begin
    cal_result_t exp_res;
    int stall;
    out_bus.ready = 1'b0;
    forever begin
      stall = idle_en ? $urandom_range(0, 4) : 0;
      repeat (stall) begin
        @(negedge clk_i);
        out_bus.ready <= 1'b0;
      end
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (hold_len) begin
          @(negedge clk_i);
          out_bus.ready <= 1'b0;
        end
      end
      @(negedge clk_i);
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (out_bus.valid !== 1'b1);
      checked_cnt++;
      if (cal_expect_q.size() == 0) begin
        $error("result with nothing expected: action=%0d calibrated_uv=%0d",
               out_bus.action, out_bus.calibrated_uv);
        err_cnt++;
      end else begin
        exp_res = cal_expect_q.pop_front();
        if (exp_res.action == avs_vc_pkg::ACT_DONE) done_cnt++;
        if (out_bus.action !== exp_res.action) begin
          $error("action: expected %0d, got %0d", exp_res.action, out_bus.action);
          err_cnt++;
        end
        if (out_bus.calibrated_uv !== exp_res.cal_uv) begin
          $error("calibrated_uv: expected %0d, got %0d", exp_res.cal_uv,
                 out_bus.calibrated_uv);
          err_cnt++;
        end
        if (out_bus.rescale_needed !== exp_res.rescale) begin
          $error("rescale_needed: expected %0d, got %0d", exp_res.rescale,
                 out_bus.rescale_needed);
          err_cnt++;
        end
        if (out_bus.margin_refused !== exp_res.refused) begin
          $error("margin_refused: expected %0d, got %0d", exp_res.refused,
                 out_bus.margin_refused);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = avs_vc_pkg::CFG_NOMINAL;
    cfg_wdata_i       = '0;
    in_bus.valid      = 1'b0;
    in_bus.func       = avs_vc_pkg::FUNC_ENABLE;
    in_bus.volt_uv    = '0;
    in_bus.volt_reset = 1'b0;
    idle_en           = 1'b1;
    hold_req          = 1'b0;
    hold_len          = 0;
    err_cnt           = 0;
    checked_cnt       = 0;
    done_cnt          = 0;
    useful_cnt        = 0;
    sent_cnt          = 0;
    cfg_writes        = 0;
    cycle_cnt         = 0;
    reg_nominal       = avs_vc_pkg::NOMINAL_RESET;
    reg_margin        = '0;
    reg_allow_hv      = 1'b0;
    st_active         = 1'b0;
    st_armed          = 1'b0;
    st_ticks          = 0;
    st_count          = 0;
    st_wptr           = 0;
    st_cal            = '0;
    for (int i = 0; i < RING_DEPTH; i++) st_ring[i] = '0;

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    test_idle_commands();
    test_full_calibration();
    test_silent_and_stop();
    test_high_nominal();

    run_random(160, avs_vc_pkg::NOMINAL_RESET, '0, 1'b0, 1'b1);
    run_random(160, UV_MAX, MARGIN_MAX, 1'b1, 1'b1);
    run_random(160, '0, '0, 1'b0, 1'b0);
    run_random(100, 21'd1400000, 18'd20000, 1'b0, 1'b1);
    run_random(160, avs_vc_pkg::HIGH_NOMINAL_LIMIT, MARGIN_MAX, 1'b0, 1'b1);
    run_random(160, UV_W'($urandom_range(600000, 1300000)),
               MARGIN_W'($urandom_range(0, MARGIN_MAX)), 1'($urandom()), 1'b1);
    test_backpressure();

    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (cal_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLE) @(posedge clk_i);

    $display("Sent %0d transactions (%0d with effect), checked %0d, %0d finished, %0d writes",
             sent_cnt, useful_cnt, checked_cnt, done_cnt, cfg_writes);
    $display("Nominal swept from zero to full scale, margin off to full, HV gate both ways");
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/avs_vc_pkg.sv
hdl/avs_vc_if.sv
hdl/avs_vc_datapath.sv
hdl/avs_vc_ctrl.sv
hdl/avs_voltage_calibration_ctrl_unit.sv
tb/tb_avs_voltage_calibration_ctrl_unit.sv
